>>> rtl/rdce_pkg.sv
// ----------------------------------------------------------------------------
// Register datagram CRC encoder package
// Shared types, datagram constants and the CRC-8 byte update function.
// ----------------------------------------------------------------------------
package rdce_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [6:0]  reg_address;
    logic [31:0] reg_value;
    logic [1:0]  channel;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] out_channel;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [7:0]  node_byte;
    logic [7:0]  addr_byte;
    logic [31:0] value;
    logic [2:0]  last_idx;
    logic [1:0]  channel;
  } dgram_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  localparam logic [7:0] SyncWrite = 8'h05;
  localparam logic [7:0] SyncRead  = 8'h55;
  localparam logic [7:0] WriteFlag = 8'h80;
  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] CrcInit   = 8'h00;

  localparam logic [2:0] IdxSync   = 3'd0;
  localparam logic [2:0] IdxNode   = 3'd1;
  localparam logic [2:0] IdxAddr   = 3'd2;
  localparam logic [2:0] IdxValue3 = 3'd3;
  localparam logic [2:0] IdxValue2 = 3'd4;
  localparam logic [2:0] IdxValue1 = 3'd5;
  localparam logic [2:0] IdxValue0 = 3'd6;
  localparam logic [2:0] LastIdxWrite = 3'd7;
  localparam logic [2:0] LastIdxRead  = 3'd3;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[7] ^ data[k];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

endpackage

>>> rtl/register_datagram_crc_encoder_unit.sv
// ----------------------------------------------------------------------------
// Register datagram CRC encoder unit
// Turns register access requests into register datagrams with CRC-8.
// ----------------------------------------------------------------------------
// Each request becomes a datagram (8 bytes for a write, 4 for a read) that
// leaves one byte per cycle while results are popped, set by the serializer,
// which loads one byte into the result register per cycle unless an unpopped
// result holds it, and starts the next datagram right after the CRC byte
// of the previous one. A two-entry queue holds requests for the serializer,
// so one is taken while results wait. The node address is sampled on accept.
module register_datagram_crc_encoder_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           push,
  output logic           full,
  input  rdce_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output rdce_pkg::rsp_t rsp_o
);
  import rdce_pkg::*;

  queue_status_t q_status;
  dgram_t        q_wdata;
  dgram_t        q_rdata;
  logic          q_push;
  logic          q_pop;

  rdce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .q_status_i  (q_status),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  rdce_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  rdce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_status.valid)
    else $error("serializer pulled from an empty queue");

  a_full_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> q_status.valid)
    else $error("queue reports full without a valid entry");

  a_no_gap_in_datagram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !rsp_o.last_byte) |=> !empty)
    else $error("gap inside a datagram");
`endif

endmodule

>>> rtl/rdce_front.sv
// ----------------------------------------------------------------------------
// Register datagram CRC encoder front end
// Holds the node address and turns an accepted request into a datagram
// descriptor for the queue.
// ----------------------------------------------------------------------------
module rdce_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   push,
  output logic                   full,
  input  rdce_pkg::req_t         req_i,
  input  rdce_pkg::queue_status_t q_status_i,
  output logic                   q_push_o,
  output rdce_pkg::dgram_t       q_data_o
);
  import rdce_pkg::*;

  logic [7:0] node_q;
  logic [7:0] node_d;

  always_comb begin
    node_d = cfg_we_i ? cfg_wdata_i : node_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= 8'h00;
    end else begin
      node_q <= node_d;
    end
  end

  assign full     = q_status_i.full;
  assign q_push_o = push && !q_status_i.full;

  always_comb begin
    q_data_o.node_byte = node_q;
    q_data_o.value     = req_i.reg_value;
    q_data_o.channel   = req_i.channel;
    case (req_i.op)
      OP_WRITE: begin
        q_data_o.sync_byte = SyncWrite;
        q_data_o.addr_byte = {1'b0, req_i.reg_address} | WriteFlag;
        q_data_o.last_idx  = LastIdxWrite;
      end
      OP_READ: begin
        q_data_o.sync_byte = SyncRead;
        q_data_o.addr_byte = {1'b0, req_i.reg_address};
        q_data_o.last_idx  = LastIdxRead;
      end
      default: begin
        q_data_o.sync_byte = SyncRead;
        q_data_o.addr_byte = {1'b0, req_i.reg_address};
        q_data_o.last_idx  = LastIdxRead;
      end
    endcase
  end

endmodule

>>> rtl/rdce_queue.sv
// ----------------------------------------------------------------------------
// Register datagram CRC encoder descriptor queue
// Short register FIFO between the front end and the serializer.
// ----------------------------------------------------------------------------
module rdce_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  rdce_pkg::dgram_t        data_i,
  input  logic                    pop_i,
  output rdce_pkg::dgram_t        data_o,
  output rdce_pkg::queue_status_t status_o
);
  import rdce_pkg::*;

  dgram_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == QueueCntW'(QueueDepth));

endmodule

>>> rtl/rdce_back.sv
// ----------------------------------------------------------------------------
// Register datagram CRC encoder serializer
// Emits one datagram byte per cycle into the result register unless it waits
// for pop; each byte folds into the running CRC, which closes the datagram.
// ----------------------------------------------------------------------------
module rdce_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rdce_pkg::queue_status_t q_status_i,
  input  rdce_pkg::dgram_t        q_data_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output rdce_pkg::rsp_t          rsp_o
);
  import rdce_pkg::*;

  dgram_t     desc_q, desc_d;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       out_q, out_d;
  logic       advance;
  logic       at_last;
  logic [7:0] data_byte;

  assign advance = !out_valid_q || pop;
  assign at_last = (idx_q == desc_q.last_idx);
  assign q_pop_o = q_status_i.valid && (!busy_q || (advance && at_last));

  always_comb begin
    case (idx_q)
      IdxSync:   data_byte = desc_q.sync_byte;
      IdxNode:   data_byte = desc_q.node_byte;
      IdxAddr:   data_byte = desc_q.addr_byte;
      IdxValue3: data_byte = desc_q.value[31:24];
      IdxValue2: data_byte = desc_q.value[23:16];
      IdxValue1: data_byte = desc_q.value[15:8];
      IdxValue0: data_byte = desc_q.value[7:0];
      default:   data_byte = 8'h00;
    endcase
  end

  always_comb begin
    desc_d      = desc_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_d.out_byte    = at_last ? crc_q : data_byte;
        out_d.last_byte   = at_last;
        out_d.out_channel = desc_q.channel;
        crc_d             = crc8_byte(crc_q, data_byte);
        idx_d             = idx_q + 3'd1;
        busy_d            = !at_last;
      end
    end
    if (q_pop_o) begin
      desc_d = q_data_i;
      busy_d = 1'b1;
      idx_d  = IdxSync;
      crc_d  = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= IdxSync;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    crc_q  <= crc_d;
    out_q  <= out_d;
  end

  assign empty = !out_valid_q;
  assign rsp_o = out_q;

endmodule
